FILE: sv/assert_macros.svh
// Assertion helpers for the signature table RTL.
// Used by files that assert on i_clk with reset i_rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset.
`define TST_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge i_clk) \
    disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent implies consequent at the following edge.
`define TST_ASSERT_NEXT(lbl, ante, cons, msg) lbl: assert property (@(posedge i_clk) \
    disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/tst_pkg.sv
// Shared types and constants for the trusted signature table.
// No dependencies; imported by tst_seq, trusted_signature_table and the testbench.
`default_nettype none

package tst_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int WORD_W      = 64;
    localparam int WORDS       = 4;
    localparam int SIG_W       = WORD_W * WORDS;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int COUNT_W     = 7;
    localparam int OUT_FIELD_W = 3 + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef logic [SIG_W-1:0] t_sig;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_sig              wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

    typedef struct packed {
        logic               table_intact;
        logic [COUNT_W-1:0] entry_count;
        logic               accepted;
        logic               is_trusted;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/trusted_signature_table.sv
// Top level of the trusted signature table: sequencer, entry store, output register.
// Depends on tst_pkg, tst_seq, tst_ram and assert_macros.svh.
//
//  channel | dir | tdata (low bit up)                              | tuser
//  s       | in  | sig_word0, sig_word1, sig_word2, sig_word3      | operation
//  m       | out | is_trusted, accepted, entry_count, table_intact | -
//
// Insert: written in S_DECIDE, then S_RESULT. Lookup: reads up to stored_count entries
// (at most MAX_ENTRIES), stops early on a hit and skips the scan on an empty table;
// one 256-bit entry read per cycle from the RAM port.
// Synchronous active-low reset clears count and integrity flag; no clearing pass.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

`include "assert_macros.svh"

module trusted_signature_table (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    input  wire  [tst_pkg::SIG_W-1:0]         i_s_tdata,  // sig_word0..sig_word3
    input  wire  [0:0]                        i_s_tuser,  // operation
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    output logic [tst_pkg::OUT_TDATA_W-1:0]   o_m_tdata   // is_trusted, accepted,
                                                          // entry_count, table_intact
);
    import tst_pkg::*;

    t_ram_req w_ram;
    t_sig     w_rd_data;
    t_result  w_res;
    logic     w_res_vld;
    logic     w_res_rdy;
    logic     r_out_vld;
    t_result  r_out;

    tst_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_vld  (i_s_tvalid),
        .o_in_rdy  (o_s_tready),
        .i_op      (i_s_tuser[0]),
        .i_sig     (i_s_tdata),
        .o_ram     (w_ram),
        .i_rd_data (w_rd_data),
        .o_res_vld (w_res_vld),
        .i_res_rdy (w_res_rdy),
        .o_res     (w_res)
    );

    tst_ram #(
        .WIDTH (SIG_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram.wr_en),
        .i_wr_addr (w_ram.wr_addr),
        .i_wr_data (w_ram.wr_data),
        .i_rd_en   (w_ram.rd_en),
        .i_rd_addr (w_ram.rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_res_rdy = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_rdy) begin
            r_out_vld <= w_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_rdy && w_res_vld) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, r_out};

    `TST_ASSERT(a_rw_excl, !(w_ram.wr_en && w_ram.rd_en), "store read and write overlap")
    `TST_ASSERT(a_hit_xor_acc, !(o_m_tvalid && r_out.is_trusted && r_out.accepted), "result both trusted and accepted")
    `TST_ASSERT_NEXT(a_wr_busy, w_ram.wr_en, !o_s_tready && o_m_tvalid == $past(r_out_vld && !i_m_tready), "insert write outside item")

endmodule

`default_nettype wire

FILE: sv/tst_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                       i_clk,
    input  wire                                       i_wr_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]                          i_wr_data,
    input  wire                                       i_rd_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/tst_seq.sv
// Sequencer: takes one item, writes inserts, scans the store for lookups.
// Depends on tst_pkg; drives the tst_ram request bundle.
`default_nettype none

module tst_seq (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_vld,
    output logic                    o_in_rdy,
    input  wire                     i_op,
    input  wire  tst_pkg::t_sig     i_sig,
    output tst_pkg::t_ram_req       o_ram,
    input  wire  tst_pkg::t_sig     i_rd_data,
    output logic                    o_res_vld,
    input  wire                     i_res_rdy,
    output tst_pkg::t_result        o_res
);
    import tst_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]       r_state, n_state;
    logic             r_op;
    t_sig             r_sig;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_zero, n_zero;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_cmp_vld, n_cmp_vld;
    logic             r_cmp_last, n_cmp_last;
    logic             r_hit, n_hit;
    logic             r_accepted, n_accepted;
    logic             w_issue;
    logic             w_full;

    assign w_full  = (r_count >= CNT_W'(MAX_ENTRIES));
    assign w_issue = (r_state == S_SCAN) && (r_rd_idx < r_count);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_zero     = r_zero;
        n_rd_idx   = r_rd_idx;
        n_hit      = r_hit;
        n_accepted = r_accepted;
        n_cmp_vld  = w_issue;
        n_cmp_last = w_issue && (r_rd_idx == (r_count - CNT_W'(1)));

        o_ram.wr_en   = 1'b0;
        o_ram.wr_addr = r_count[ADDR_W-1:0];
        o_ram.wr_data = r_sig;
        o_ram.rd_en   = w_issue;
        o_ram.rd_addr = r_rd_idx[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_vld) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_hit      = 1'b0;
                n_accepted = 1'b0;
                n_rd_idx   = '0;
                if (r_op == OP_INSERT) begin
                    n_state = S_RESULT;
                    if (!w_full) begin
                        o_ram.wr_en = 1'b1;
                        n_count     = r_count + CNT_W'(1);
                        n_accepted  = 1'b1;
                        if (r_sig == '0) begin
                            n_zero = 1'b1;
                        end
                    end
                end else if (r_count == '0) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_issue) begin
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end
                if (r_cmp_vld && (i_rd_data == r_sig)) begin
                    n_hit   = 1'b1;
                    n_state = S_RESULT;
                end else if (r_cmp_vld && r_cmp_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_res_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_zero     <= 1'b0;
            r_rd_idx   <= '0;
            r_cmp_vld  <= 1'b0;
            r_cmp_last <= 1'b0;
            r_hit      <= 1'b0;
            r_accepted <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_zero     <= n_zero;
            r_rd_idx   <= n_rd_idx;
            r_cmp_vld  <= n_cmp_vld;
            r_cmp_last <= n_cmp_last;
            r_hit      <= n_hit;
            r_accepted <= n_accepted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_rdy && i_in_vld) begin
            r_op  <= i_op;
            r_sig <= i_sig;
        end
    end

    assign o_in_rdy  = (r_state == S_IDLE);
    assign o_res_vld = (r_state == S_RESULT);

    assign o_res.is_trusted   = r_hit;
    assign o_res.accepted     = r_accepted;
    assign o_res.entry_count  = COUNT_W'(r_count);
    assign o_res.table_intact = !r_zero;

endmodule

`default_nettype wire

FILE: sim/trusted_signature_table_tb.sv
// Self-checking testbench for trusted_signature_table: lookups and inserts of 256-bit
// signatures, predicted by a scoreboard class that keeps its own copy of the table.
// Depends on tst_pkg and the trusted_signature_table RTL.

module trusted_signature_table_tb;
    import tst_pkg::*;

    localparam int RX_HOLD_CYCLES = 400;

    class allowlist_scoreboard;
        t_sig        entry_sig [MAX_ENTRIES];
        int unsigned count;
        bit          zero_seen;
        t_result     replies_due [$];
        int          errors, lookups, hits, stored, refused;

        function t_result predict_reply(logic op, t_sig sig);
            t_result r;
            r = '0;
            if (op == OP_LOOKUP) begin
                lookups++;
                for (int i = 0; i < count; i++) begin
                    if (entry_sig[i] == sig) r.is_trusted = 1'b1;
                end
                if (r.is_trusted) hits++;
            end else if (count < MAX_ENTRIES) begin
                entry_sig[count] = sig;
                if (sig == '0) zero_seen = 1'b1;
                count++;
                r.accepted = 1'b1;
                stored++;
            end else begin
                refused++;
            end
            r.entry_count  = COUNT_W'(count);
            r.table_intact = !zero_seen;
            return r;
        endfunction

        function void note_request(logic op, t_sig sig);
            replies_due.push_back(predict_reply(op, sig));
        endfunction

        task report_mismatch(string what, longint got, longint want);
            errors++;
            if (errors <= 40)
                $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        endtask

        task check_reply(logic [OUT_TDATA_W-1:0] tdata);
            t_result got, want;
            got = t_result'(tdata[OUT_FIELD_W-1:0]);
            if (replies_due.size() == 0) begin
                report_mismatch("result with nothing outstanding", tdata, 0);
                return;
            end
            want = replies_due.pop_front();
            if (got.is_trusted != want.is_trusted)
                report_mismatch("is_trusted", got.is_trusted, want.is_trusted);
            if (got.accepted != want.accepted)
                report_mismatch("accepted", got.accepted, want.accepted);
            if (got.entry_count != want.entry_count)
                report_mismatch("entry_count", got.entry_count, want.entry_count);
            if (got.table_intact != want.table_intact)
                report_mismatch("table_intact", got.table_intact, want.table_intact);
        endtask
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    t_sig                   i_s_tdata  = '0;    // sig_word0, sig_word1, sig_word2, sig_word3
    logic [0:0]             i_s_tuser  = '0;    // operation
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;          // is_trusted, accepted, entry_count, table_intact

    allowlist_scoreboard sb = new();
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          rx_holding  = 1'b0;
    event        rx_hold_go;

    trusted_signature_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (rx_holding) i_m_tready = 1'b0;
        else i_m_tready = ($urandom_range(99) >= rx_idle_pct);
    end

    initial forever begin
        @(rx_hold_go);
        rx_holding = 1'b1;
        repeat (RX_HOLD_CYCLES) @(negedge i_clk);
        rx_holding = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_reply(o_m_tdata);
    end

    function logic [WORD_W-1:0] random_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5) return '0;
        if (pick < 10) return '1;
        return {$urandom, $urandom};
    endfunction

    // Lookups mostly hit or nearly hit stored entries; inserts are mostly fresh.
    function t_sig make_sig(logic op);
        int unsigned pick;
        t_sig s;
        pick = $urandom_range(99);
        if (sb.count != 0 && pick < ((op == OP_LOOKUP) ? 45 : 15))
            return sb.entry_sig[$urandom_range(sb.count - 1)];
        if (sb.count != 0 && op == OP_LOOKUP && pick < 70) begin
            s = sb.entry_sig[$urandom_range(sb.count - 1)];
            s[$urandom_range(SIG_W - 1)] ^= 1'b1;
            return s;
        end
        return {random_word(), random_word(), random_word(), random_word()};
    endfunction

    task send_item(input logic op, input t_sig sig);
        @(negedge i_clk);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = sig;
        i_s_tuser  = op;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(op, sig);
    endtask

    task wait_drained();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.replies_due.size() != 0) @(posedge i_clk);
    endtask

    task random_items(input int n, input int unsigned insert_pct);
        logic op;
        repeat (n) begin
            op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_LOOKUP;
            send_item(op, make_sig(op));
        end
    endtask

    initial begin
        t_sig s;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table, exact and near matches, word boundaries
        send_item(OP_LOOKUP, '0);
        send_item(OP_LOOKUP, '1);
        send_item(OP_INSERT, '1);
        send_item(OP_LOOKUP, '1);
        send_item(OP_LOOKUP, {{(SIG_W-1){1'b1}}, 1'b0});
        for (int w = 0; w < WORDS; w++) begin
            s = '1;
            s[w*WORD_W +: WORD_W] = '0;
            send_item(OP_LOOKUP, s);
        end
        send_item(OP_INSERT, {(SIG_W/2){2'b10}});
        send_item(OP_LOOKUP, {(SIG_W/2){2'b10}});
        send_item(OP_LOOKUP, {(SIG_W/2){2'b01}});
        send_item(OP_INSERT, {1'b1, {(SIG_W-1){1'b0}}});
        send_item(OP_LOOKUP, {1'b1, {(SIG_W-1){1'b0}}});
        send_item(OP_LOOKUP, {{(SIG_W-1){1'b0}}, 1'b1});
        send_item(OP_INSERT, '1);
        send_item(OP_LOOKUP, '1);

        tx_idle_pct = 31;
        rx_idle_pct = 67;
        random_items(560, 4);
        wait_drained();

        // all-zero entry drops the integrity flag for good
        send_item(OP_INSERT, '0);
        send_item(OP_LOOKUP, '0);
        send_item(OP_LOOKUP, {{(SIG_W-1){1'b0}}, 1'b1});

        tx_idle_pct = 67;
        rx_idle_pct = 31;
        random_items(560, 4);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        -> rx_hold_go;
        random_items(560, 25);

        // full table refuses inserts
        send_item(OP_INSERT, '1);
        send_item(OP_LOOKUP, '1);
        wait_drained();
        repeat (MAX_ENTRIES + 8) @(posedge i_clk);

        $display("Ran %0d lookups (%0d hits) and %0d inserts (%0d refused when full).",
                 sb.lookups, sb.hits, sb.stored + sb.refused, sb.refused);
        $display("Table reached %0d entries; all-zero entry stored: %0d.",
                 sb.count, sb.zero_seen);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
